// ----- rtl/lruocd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lruocd_pkg
// Shared types and constants of the LRU object cache directory.
// ----------------------------------------------------------------------------
package lruocd_pkg;

  localparam int KEY_W  = 64;
  localparam int LEN_W  = 21;
  localparam int SLOT_W = 6;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(1024 * 1024);

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_ADD    = 1'b1
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] length;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  stored_length;
    logic              accepted;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
  } rsp_t;

  // Control broadcast to every cell of the recency chain.
  typedef struct packed {
    logic capture;    // latch per-cell key compare
    logic move;       // move the selected entry to the front
    logic use_match;  // select by key match, else by insert point
  } cell_ctrl_t;

endpackage

// ----- rtl/lruocd_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lruocd_cell
// One recency position: holds an entry, compares its key, shifts in from the
// neighbor above when an entry moves to the front.
// ----------------------------------------------------------------------------
module lruocd_cell #(
  parameter int KEY_BITS = 64,
  parameter int INDEX    = 0,
  parameter bit LAST     = 1'b0
) (
  input  logic                             clk,
  input  logic                             rst,
  input  lruocd_pkg::cell_ctrl_t           ctrl,
  input  logic [KEY_BITS-1:0]              cmp_key,
  input  logic                             nb_valid,
  input  logic                             in_valid,
  input  logic [lruocd_pkg::SLOT_W-1:0]    in_slot,
  input  logic [KEY_BITS-1:0]              in_key,
  input  logic [lruocd_pkg::LEN_W-1:0]     in_len,
  input  logic                             found_in,
  output logic                             found_out,
  output logic                             sel,
  output logic                             match,
  output logic                             valid,
  output logic [lruocd_pkg::SLOT_W-1:0]    slot,
  output logic [KEY_BITS-1:0]              key,
  output logic [lruocd_pkg::LEN_W-1:0]     len
);

  logic ins_here;
  logic shift;

  // First empty position, or the tail when the chain is full.
  assign ins_here  = (!valid && nb_valid) || (LAST && valid);
  assign sel       = ctrl.move && (ctrl.use_match ? match : ins_here);
  assign found_out = found_in || sel;
  assign shift     = ctrl.move && !found_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      slot  <= lruocd_pkg::SLOT_W'(INDEX);
      match <= 1'b0;
    end else begin
      if (ctrl.capture) begin
        match <= valid && (key == cmp_key);
      end
      if (shift) begin
        valid <= in_valid;
        slot  <= in_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      key <= in_key;
      len <= in_len;
    end
  end

endmodule

// ----- rtl/lru_object_cache_directory.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_object_cache_directory
// Fully associative directory with least-recently-used replacement, built as
// a chain of recency cells with the most recent entry in cell 0.
// ----------------------------------------------------------------------------
// Requests: start is ignored while busy; busy is high for the one update
//   cycle after each accepted request, set by compare-then-shift over the chain.
// Result: done holds for exactly one cycle; result holds until the next update;
//   the receiver cannot stall.
// Reset: all cells empty, slots in identity order, max_object_len = 1 MiB.
// ----------------------------------------------------------------------------
module lru_object_cache_directory #(
  parameter int ENTRIES  = 10,
  parameter int KEY_BITS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  lruocd_pkg::req_t             request,
  output logic                         done,
  output lruocd_pkg::rsp_t             result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lruocd_pkg::LEN_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_UPDATE = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration register: writes are always taken.
  logic [lruocd_pkg::LEN_W-1:0] max_object_len;

  // Request held across the update cycle.
  lruocd_pkg::op_e              op_q;
  logic [KEY_BITS-1:0]          key_q;
  logic [lruocd_pkg::LEN_W-1:0] len_q;
  logic                         oversize_q;

  logic accept;

  // Per-cell views of the chain.
  logic                         cell_valid [ENTRIES];
  logic [lruocd_pkg::SLOT_W-1:0] cell_slot [ENTRIES];
  logic [KEY_BITS-1:0]          cell_key   [ENTRIES];
  logic [lruocd_pkg::LEN_W-1:0] cell_len   [ENTRIES];
  logic                         cell_match [ENTRIES];
  logic                         cell_sel   [ENTRIES];
  logic                         found      [ENTRIES+1];
  logic [ENTRIES-1:0]           valid_vec;

  lruocd_pkg::cell_ctrl_t       ctrl;

  logic                         hit_any;
  logic                         is_add;
  logic                         do_move;
  logic [lruocd_pkg::SLOT_W-1:0] sel_slot;
  logic [KEY_BITS-1:0]          sel_key;
  logic [lruocd_pkg::LEN_W-1:0] sel_len;
  logic [lruocd_pkg::LEN_W-1:0] front_len;
  lruocd_pkg::rsp_t             result_next;

  assign cfg_ready = 1'b1;
  assign busy      = (state == ST_UPDATE);
  assign accept    = start && !busy;

  always_comb begin
    unique case (state)
      ST_IDLE:   state_next = accept ? ST_UPDATE : ST_IDLE;
      ST_UPDATE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      max_object_len <= lruocd_pkg::MAX_LEN_RESET;
      done           <= 1'b0;
    end else begin
      state <= state_next;
      done  <= busy;
      if (cfg_valid && cfg_ready) begin
        max_object_len <= cfg_data;
      end
    end
  end

  // Latch the request and the size check at the accept edge; the cells latch
  // their key compares at the same edge.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q       <= request.op;
      key_q      <= request.key[KEY_BITS-1:0];
      len_q      <= request.length;
      oversize_q <= (request.length > max_object_len);
    end
    if (busy) begin
      result <= result_next;
    end
  end

  // Decide the update: a hit moves the matching cell, an add that misses moves
  // the insert point (first empty cell, or the tail which is evicted); an oversize add moves nothing.
  always_comb begin
    hit_any = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_any = hit_any | cell_match[i];
    end
  end

  assign is_add  = (op_q == lruocd_pkg::OP_ADD);
  assign do_move = busy && !(is_add && oversize_q) && (hit_any || is_add);

  assign ctrl.capture   = accept;
  assign ctrl.move      = do_move;
  assign ctrl.use_match = hit_any;

  // Gather the selected cell; at most one cell is selected.
  always_comb begin
    sel_slot = '0;
    sel_key  = '0;
    sel_len  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (cell_sel[i]) begin
        sel_slot = sel_slot | cell_slot[i];
        sel_key  = sel_key | cell_key[i];
        sel_len  = sel_len | cell_len[i];
      end
    end
  end

  // An add writes its length; a lookup keeps the stored one.
  assign front_len = is_add ? len_q : sel_len;

  always_comb begin
    result_next = '0;
    if (do_move) begin
      result_next.hit           = hit_any;
      result_next.slot          = sel_slot;
      result_next.stored_length = front_len;
      result_next.accepted      = is_add;
      if (is_add && !hit_any && cell_valid[ENTRIES-1]) begin
        result_next.evicted     = 1'b1;
        result_next.evicted_key = lruocd_pkg::KEY_W'(sel_key);
      end
    end
  end

  assign found[0] = 1'b0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    logic                          nb_valid;
    logic                          in_valid;
    logic [lruocd_pkg::SLOT_W-1:0] in_slot;
    logic [KEY_BITS-1:0]           in_key;
    logic [lruocd_pkg::LEN_W-1:0]  in_len;

    // Cell 0 takes the moved entry; every other cell takes its upper neighbor.
    if (g == 0) begin : g_front
      assign nb_valid = 1'b1;
      assign in_valid = 1'b1;
      assign in_slot  = sel_slot;
      assign in_key   = key_q;
      assign in_len   = front_len;
    end else begin : g_body
      assign nb_valid = cell_valid[g-1];
      assign in_valid = cell_valid[g-1];
      assign in_slot  = cell_slot[g-1];
      assign in_key   = cell_key[g-1];
      assign in_len   = cell_len[g-1];
    end

    lruocd_cell #(
      .KEY_BITS (KEY_BITS),
      .INDEX    (g),
      .LAST     (g == ENTRIES - 1)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .cmp_key   (request.key[KEY_BITS-1:0]),
      .nb_valid  (nb_valid),
      .in_valid  (in_valid),
      .in_slot   (in_slot),
      .in_key    (in_key),
      .in_len    (in_len),
      .found_in  (found[g]),
      .found_out (found[g+1]),
      .sel       (cell_sel[g]),
      .match     (cell_match[g]),
      .valid     (cell_valid[g]),
      .slot      (cell_slot[g]),
      .key       (cell_key[g]),
      .len       (cell_len[g])
    );

    assign valid_vec[g] = cell_valid[g];
  end

  // Occupied cells always form a prefix of the chain.
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & ENTRIES'(valid_vec + 1'b1)) == '0)
    else $error("occupied cells are not a prefix of the chain");

  // A result follows exactly one update cycle.
  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without an update cycle");

  // An accepted transaction always enters the update cycle.
  a_accept_update: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction skipped the update cycle");

  // An eviction only comes from an accepted add that missed on a full chain.
  a_evict_add_miss: assert property (@(posedge clk) disable iff (rst)
    (done && result.evicted) |-> (result.accepted && !result.hit))
    else $error("eviction reported for a hit or a rejected transaction");

  // Every move picks some cell of the chain to bring to the front.
  a_move_selects: assert property (@(posedge clk) disable iff (rst)
    do_move |-> found[ENTRIES])
    else $error("update moved no cell of the chain");

endmodule
